// ===== hw/rtl/hdts_pkg.sv =====
// ----------------------------------------------------------------------------
// HID descriptor transfer size scan: shared definitions
// Parser phases, register load codes, item tag constants and the event record
// that passes from the parsing front end to the arithmetic back end.
// ----------------------------------------------------------------------------
package hdts_pkg;

  localparam int unsigned QueueDepth = 4;

  localparam logic [2:0] PhHeader  = 3'd0;
  localparam logic [2:0] PhFirst   = 3'd1;
  localparam logic [2:0] PhRest    = 3'd2;
  localparam logic [2:0] PhLongLen = 3'd3;
  localparam logic [2:0] PhLongTag = 3'd4;
  localparam logic [2:0] PhLongSkp = 3'd5;

  typedef enum logic [1:0] {
    LdNone  = 2'd0,
    LdCount = 2'd1,
    LdSize  = 2'd2
  } load_kind_e;

  localparam logic [3:0] TagLongMark    = 4'd15;
  localparam logic [3:0] TagCountOrOut  = 4'd9;
  localparam logic [3:0] TagReportSize  = 4'd7;
  localparam logic [1:0] TypeMain       = 2'd0;
  localparam logic [1:0] TypeGlobal     = 2'd1;
  localparam logic [1:0] TypeLongMark   = 2'd3;
  localparam logic [1:0] SizeLongMark   = 2'd2;
  localparam int unsigned BitsPerByteLog = 3;

  typedef struct packed {
    load_kind_e  ld_kind;
    logic [7:0]  ld_val;
    logic        do_output;
    logic        last;
  } event_t;

endpackage

// ===== hw/rtl/hid_descriptor_transfer_size_scan_core.sv =====
// ----------------------------------------------------------------------------
// HID descriptor transfer size scan
// Parses a HID report descriptor one byte per request and reports, on the
// final byte, the largest output report size in whole bytes.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload                         Handshake
//  in        request    desc_byte_i[7:0], last_byte_i   in_valid_i / in_ready_o
//  out       response   transfer_bytes_o[12:0]          out_valid_o / out_ready_i
//
// One byte is accepted per cycle while the event queue has room.
// The last byte's event enters the queue when the byte is accepted; the back end
// moves it into the output register once it reaches the queue head and any
// earlier result has been taken, which registers the result and raises out_valid_o.
// Reset clears parser, queue pointers and back-end state; nothing needs sweeping.
// A stalled result holds only the back end; the parser keeps accepting bytes
// until the queue of QUEUE_DEPTH events is full.
// ----------------------------------------------------------------------------
module hid_descriptor_transfer_size_scan_core #(
  parameter int unsigned QUEUE_DEPTH = hdts_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  desc_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [12:0] transfer_bytes_o
);

  hdts_pkg::event_t push_evt, head_evt;
  logic             push, full, head_valid, pop;

  hdts_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .desc_byte_i (desc_byte_i),
    .last_byte_i (last_byte_i),
    .evt_push_o  (push),
    .evt_o       (push_evt),
    .evt_full_i  (full)
  );

  hdts_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_evt),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .data_o  (head_evt)
  );

  hdts_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .evt_valid_i      (head_valid),
    .evt_i            (head_evt),
    .evt_pop_o        (pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .transfer_bytes_o (transfer_bytes_o)
  );

endmodule

// ===== hw/rtl/hdts_front.sv =====
// ----------------------------------------------------------------------------
// HID descriptor transfer size scan: item parser
// Splits the byte stream into items and emits one event for each byte that
// loads a register, updates the maximum or ends the descriptor.
// ----------------------------------------------------------------------------
module hdts_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          desc_byte_i,
  input  logic                last_byte_i,
  output logic                evt_push_o,
  output hdts_pkg::event_t    evt_o,
  input  logic                evt_full_i
);

  logic [2:0] phase_q, phase_d;
  logic [7:0] left_q, left_d;
  logic [3:0] tag_q, tag_d;
  logic [1:0] type_q, type_d;
  logic [7:0] first_q, first_d;
  hdts_pkg::load_kind_e pend_q, pend_d;

  logic             accept;
  logic [7:0]       left_dec;
  logic             finish;
  logic [7:0]       finish_val;
  hdts_pkg::event_t evt;

  assign in_ready_o = !evt_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign left_dec   = left_q - 8'd1;

  always_comb begin
    phase_d    = phase_q;
    left_d     = left_q;
    tag_d      = tag_q;
    type_d     = type_q;
    first_d    = first_q;
    pend_d     = hdts_pkg::LdNone;
    finish     = 1'b0;
    finish_val = first_q;
    evt.ld_kind   = pend_q;
    evt.ld_val    = desc_byte_i;
    evt.do_output = 1'b0;
    evt.last      = last_byte_i;

    case (phase_q)
      hdts_pkg::PhFirst: begin
        first_d    = desc_byte_i;
        left_d     = left_dec;
        finish_val = desc_byte_i;
        if (left_dec == 8'd0) begin
          finish = 1'b1;
        end else begin
          phase_d = hdts_pkg::PhRest;
        end
      end
      hdts_pkg::PhRest: begin
        left_d = left_dec;
        finish = (left_dec == 8'd0);
      end
      hdts_pkg::PhLongLen: begin
        left_d  = desc_byte_i;
        phase_d = hdts_pkg::PhLongTag;
      end
      hdts_pkg::PhLongTag: begin
        tag_d   = desc_byte_i[3:0];
        phase_d = (left_q != 8'd0) ? hdts_pkg::PhLongSkp : hdts_pkg::PhHeader;
      end
      hdts_pkg::PhLongSkp: begin
        left_d = left_dec;
        if (left_dec == 8'd0) begin
          phase_d = hdts_pkg::PhHeader;
        end
      end
      default: begin
        tag_d  = desc_byte_i[7:4];
        type_d = desc_byte_i[3:2];
        if (desc_byte_i[1:0] == hdts_pkg::SizeLongMark &&
            desc_byte_i[3:2] == hdts_pkg::TypeLongMark &&
            desc_byte_i[7:4] == hdts_pkg::TagLongMark) begin
          phase_d = hdts_pkg::PhLongLen;
        end else if (desc_byte_i[1:0] == 2'd0) begin
          phase_d = hdts_pkg::PhHeader;
          if (desc_byte_i[3:2] == hdts_pkg::TypeGlobal) begin
            if (desc_byte_i[7:4] == hdts_pkg::TagCountOrOut) begin
              pend_d = hdts_pkg::LdCount;
            end else if (desc_byte_i[7:4] == hdts_pkg::TagReportSize) begin
              pend_d = hdts_pkg::LdSize;
            end
          end else if (desc_byte_i[3:2] == hdts_pkg::TypeMain &&
                       desc_byte_i[7:4] == hdts_pkg::TagCountOrOut) begin
            evt.do_output = 1'b1;
          end
        end else begin
          left_d  = {6'd0, desc_byte_i[1:0]};
          phase_d = hdts_pkg::PhFirst;
        end
      end
    endcase

    // A finished item never coincides with a pending load, so the load slot is free.
    if (finish) begin
      phase_d = hdts_pkg::PhHeader;
      if (type_q == hdts_pkg::TypeGlobal) begin
        evt.ld_val = finish_val;
        if (tag_q == hdts_pkg::TagCountOrOut) begin
          evt.ld_kind = hdts_pkg::LdCount;
        end else if (tag_q == hdts_pkg::TagReportSize) begin
          evt.ld_kind = hdts_pkg::LdSize;
        end
      end else if (type_q == hdts_pkg::TypeMain && tag_q == hdts_pkg::TagCountOrOut) begin
        evt.do_output = 1'b1;
      end
    end
  end

  assign evt_o      = evt;
  assign evt_push_o = accept &&
                      (evt.ld_kind != hdts_pkg::LdNone || evt.do_output || evt.last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= hdts_pkg::PhHeader;
      left_q  <= 8'd0;
      tag_q   <= 4'd0;
      type_q  <= 2'd0;
      first_q <= 8'd0;
      pend_q  <= hdts_pkg::LdNone;
    end else if (accept) begin
      if (last_byte_i) begin
        phase_q <= hdts_pkg::PhHeader;
        left_q  <= 8'd0;
        tag_q   <= 4'd0;
        type_q  <= 2'd0;
        first_q <= 8'd0;
        pend_q  <= hdts_pkg::LdNone;
      end else begin
        phase_q <= phase_d;
        left_q  <= left_d;
        tag_q   <= tag_d;
        type_q  <= type_d;
        first_q <= first_d;
        pend_q  <= pend_d;
      end
    end
  end

endmodule

// ===== hw/rtl/hdts_queue.sv =====
// ----------------------------------------------------------------------------
// HID descriptor transfer size scan: event queue
// A small register FIFO that decouples the parser from the arithmetic stage.
// ----------------------------------------------------------------------------
module hdts_queue #(
  parameter int unsigned DEPTH = hdts_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  hdts_pkg::event_t data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output hdts_pkg::event_t data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  hdts_pkg::event_t mem_q [DEPTH];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntFull);
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrLast) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrLast) ? '0 : rd_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/hdts_back.sv =====
// ----------------------------------------------------------------------------
// HID descriptor transfer size scan: arithmetic stage
// Holds report count and size, keeps the largest output report in bits and
// presents the transfer size in bytes at the end of each descriptor.
// ----------------------------------------------------------------------------
module hdts_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             evt_valid_i,
  input  hdts_pkg::event_t evt_i,
  output logic             evt_pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [12:0]      transfer_bytes_o
);

  logic [7:0]  count_q, count_d;
  logic [7:0]  size_q, size_d;
  logic [15:0] max_q, max_d;
  logic [15:0] prod;
  logic [12:0] out_q;
  logic        out_valid_q;

  assign evt_pop_o = evt_valid_i && (!evt_i.last || !out_valid_q || out_ready_i);

  always_comb begin
    count_d = count_q;
    size_d  = size_q;
    if (evt_i.ld_kind == hdts_pkg::LdCount) begin
      count_d = evt_i.ld_val;
    end else if (evt_i.ld_kind == hdts_pkg::LdSize) begin
      size_d = evt_i.ld_val;
    end
    prod  = 16'(count_d) * 16'(size_d);
    max_d = (evt_i.do_output && prod > max_q) ? prod : max_q;
  end

  always_ff @(posedge clk_i) begin
    if (evt_pop_o && evt_i.last) begin
      out_q <= max_d[15:hdts_pkg::BitsPerByteLog];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= 8'd0;
      size_q      <= 8'd0;
      max_q       <= 16'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (evt_pop_o) begin
        if (evt_i.last) begin
          count_q <= 8'd0;
          size_q  <= 8'd0;
          max_q   <= 16'd0;
        end else begin
          count_q <= count_d;
          size_q  <= size_d;
          max_q   <= max_d;
        end
      end
      if (evt_pop_o && evt_i.last) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign transfer_bytes_o = out_q;

endmodule
